[design/load_cell_trimmed_average_top_assert.svh]
// assertion macros shared by the load cell averaging block
`ifndef LOAD_CELL_TRIMMED_AVERAGE_TOP_ASSERT_SVH
`define LOAD_CELL_TRIMMED_AVERAGE_TOP_ASSERT_SVH

// same-cycle implication, held off during reset
`define LTAVG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define LTAVG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ltavg_pkg.sv]
`timescale 1ns / 1ps

package ltavg_pkg;

  // field and storage sizes
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned NET_W      = SAMPLE_W + 1;
  localparam int unsigned UNITS_W    = NET_W + 8;
  localparam int unsigned WINDOW_MAX = 32;
  localparam int unsigned SLOT_W     = $clog2(WINDOW_MAX);
  localparam int unsigned WIN_W      = 6;
  localparam int unsigned SPR_W      = 8;
  localparam int unsigned CAL_W      = 16;
  localparam int unsigned BSUM_W     = 32;
  localparam int unsigned RSUM_W     = SAMPLE_W + SLOT_W + 1;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL    = 3'd3;

  localparam logic [SPR_W-1:0] SPR_RST    = 8'd1;
  localparam logic             SMOOTH_RST = 1'b1;
  localparam logic [WIN_W-1:0] WINDOW_RST = 6'd16;
  localparam logic [CAL_W-1:0] CAL_RST    = 16'd1400;

  // input modes
  localparam int unsigned MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_SAMPLE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TARE       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUICK_TARE = 2'd2;

  // shared divider
  localparam int unsigned DIV_W     = UNITS_W;
  localparam int unsigned DVSR_W    = CAL_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  typedef struct packed {
    logic                     start;
    logic signed [DIV_W-1:0]  dividend;
    logic        [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [DIV_W-1:0] quotient;
  } div_rsp_t;

  // window clamped to 3..WINDOW_MAX
  function automatic logic [WIN_W-1:0] active_window(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] r;
    r = w;
    if (w < WIN_W'(3)) r = WIN_W'(3);
    if (w > WIN_W'(WINDOW_MAX)) r = WIN_W'(WINDOW_MAX);
    return r;
  endfunction

endpackage

[design/ltavg_if.sv]
`timescale 1ns / 1ps

// input conversions
interface ltavg_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [ltavg_pkg::MODE_W-1:0]   mode;
  logic signed [ltavg_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

// results
interface ltavg_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ltavg_pkg::SAMPLE_W-1:0] reading;
  logic signed [ltavg_pkg::NET_W-1:0]    net_counts;
  logic signed [ltavg_pkg::UNITS_W-1:0]  units_q8;

  modport source (output valid, output reading, output net_counts, output units_q8,
                  input ready);
  modport sink   (input valid, input reading, input net_counts, input units_q8,
                  output ready);
endinterface

// register writes
interface ltavg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ltavg_pkg::CFG_IDX_W-1:0]     index;
  logic [ltavg_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/load_cell_trimmed_average_top.sv]
`timescale 1ns / 1ps
// channel  | port  | direction | payload
// ---------+-------+-----------+--------------------------------------
// input    | in_i  | sink      | mode[1:0], sample[23:0] signed
// result   | out_o | source    | reading[23:0], net_counts[24:0], units_q8[32:0]
// config   | cfg_i | sink      | index[2:0], data[15:0]; always ready
//
// a sample that does not finish a reading, and every tare, is handled in the idle state
// a finished reading takes three passes through the bit-serial divider (block
// mean, trimmed mean, units) and a walk of the ring memory at one entry a cycle;
// without smoothing it takes two divider passes and no walk
// reset leaves a refill pending, so the first plain sample fills the ring
// the result register frees the input side: a new transfer is taken while a
// result still waits, and the sequencer only stalls when the next one is due

module load_cell_trimmed_average_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ltavg_in_if.sink   in_i,
  ltavg_out_if.source out_o,
  ltavg_cfg_if.sink  cfg_i
);

`include "load_cell_trimmed_average_top_assert.svh"

  localparam int unsigned SW = ltavg_pkg::SAMPLE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BDIV,
    ST_WALK,
    ST_TDIV,
    ST_NET,
    ST_UDIV,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [ltavg_pkg::SPR_W-1:0] spr_q, spr_d;
  logic                        smooth_q, smooth_d;
  logic [ltavg_pkg::WIN_W-1:0] window_q, window_d;
  logic [ltavg_pkg::CAL_W-1:0] cal_q, cal_d;

  // reading state
  logic signed [ltavg_pkg::BSUM_W-1:0] bsum_q, bsum_d;
  logic        [ltavg_pkg::SPR_W-1:0]  bcnt_q, bcnt_d;
  logic signed [SW-1:0]                tare_q, tare_d;
  logic signed [SW-1:0]                last_q, last_d;
  logic                                refill_pending_q, refill_pending_d;
  logic        [ltavg_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic signed [SW-1:0]                fill_q, fill_d;
  logic        [ltavg_pkg::WINDOW_MAX-1:0] valid_q, valid_d;

  // ring walk
  logic        [ltavg_pkg::WIN_W-1:0]  walk_cnt_q, walk_cnt_d;
  logic                                rd_pend_q, rd_pend_d;
  logic                                rd_valid_q, rd_valid_d;
  logic signed [ltavg_pkg::RSUM_W-1:0] rsum_q, rsum_d;
  logic signed [SW-1:0]                lo_q, lo_d;
  logic signed [SW-1:0]                hi_q, hi_d;

  // result path
  logic signed [SW-1:0]                 reading_q, reading_d;
  logic signed [ltavg_pkg::NET_W-1:0]   net_q, net_d;
  logic signed [ltavg_pkg::UNITS_W-1:0] units_q, units_d;
  logic                                 out_valid_q, out_valid_d;
  logic signed [SW-1:0]                 out_reading_q, out_reading_d;
  logic signed [ltavg_pkg::NET_W-1:0]   out_net_q, out_net_d;
  logic signed [ltavg_pkg::UNITS_W-1:0] out_units_q, out_units_d;

  // divider link
  ltavg_pkg::div_req_t div_req_q, div_req_d;
  ltavg_pkg::div_rsp_t div_rsp;

  // ring memory port
  logic                         ram_we;
  logic [ltavg_pkg::SLOT_W-1:0] ram_waddr;
  logic [SW-1:0]                ram_wdata;
  logic [SW-1:0]                ram_rdata;

  // helpers
  logic                                in_fire;
  logic                                cfg_wr;
  logic [ltavg_pkg::WIN_W-1:0]         win_act;
  logic [ltavg_pkg::SPR_W-1:0]         need;
  logic signed [ltavg_pkg::BSUM_W-1:0] bsum_new;
  logic        [ltavg_pkg::SPR_W-1:0]  bcnt_new;
  logic                                do_refill;
  logic signed [SW-1:0]                refill_val;
  logic signed [SW-1:0]                ent;
  logic        [ltavg_pkg::SLOT_W-1:0] slot_next;
  logic        [ltavg_pkg::CAL_W-1:0]  cal_eff;

  assign in_fire = in_i.valid && in_i.ready;
  assign cfg_wr  = cfg_i.valid && cfg_i.ready;
  assign win_act = ltavg_pkg::active_window(window_q);
  assign need    = (spr_q == '0) ? ltavg_pkg::SPR_W'(1) : spr_q;
  assign cal_eff = (cal_q == '0) ? ltavg_pkg::CAL_W'(1) : cal_q;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid      = out_valid_q;
  assign out_o.reading    = out_reading_q;
  assign out_o.net_counts = out_net_q;
  assign out_o.units_q8   = out_units_q;

  // ring entry seen by the walk: unwritten since the last refill reads as fill value
  assign ent       = rd_valid_q ? $signed(ram_rdata) : fill_q;
  assign slot_next = ({1'b0, slot_q} >= (win_act - 1'b1)) ? '0 : (slot_q + 1'b1);

  // shared divider
  ltavg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  // ring of readings
  ltavg_ram #(
    .WIDTH (SW),
    .DEPTH (ltavg_pkg::WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (walk_cnt_q[ltavg_pkg::SLOT_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // sequencer next state
  always_comb begin
    state_d          = state_q;
    spr_d            = spr_q;
    smooth_d         = smooth_q;
    window_d         = window_q;
    cal_d            = cal_q;
    bsum_d           = bsum_q;
    bcnt_d           = bcnt_q;
    tare_d           = tare_q;
    last_d           = last_q;
    refill_pending_d = refill_pending_q;
    slot_d           = slot_q;
    fill_d           = fill_q;
    valid_d          = valid_q;
    walk_cnt_d       = walk_cnt_q;
    rd_pend_d        = rd_pend_q;
    rd_valid_d       = valid_q[walk_cnt_q[ltavg_pkg::SLOT_W-1:0]];
    rsum_d           = rsum_q;
    lo_d             = lo_q;
    hi_d             = hi_q;
    reading_d        = reading_q;
    net_d            = net_q;
    units_d          = units_q;
    out_valid_d      = out_valid_q;
    out_reading_d    = out_reading_q;
    out_net_d        = out_net_q;
    out_units_d      = out_units_q;
    div_req_d        = div_req_q;
    div_req_d.start  = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = slot_next;
    ram_wdata        = reading_q;
    bsum_new         = bsum_q + ltavg_pkg::BSUM_W'(in_i.sample);
    bcnt_new         = bcnt_q + 1'b1;
    do_refill        = 1'b0;
    refill_val       = in_i.sample;

    // result taken downstream
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_i.mode)
            ltavg_pkg::MODE_TARE: begin
              tare_d    = in_i.sample;
              do_refill = 1'b1;
            end
            ltavg_pkg::MODE_QUICK_TARE: begin
              tare_d     = last_q;
              refill_val = last_q;
              do_refill  = 1'b1;
            end
            ltavg_pkg::MODE_SAMPLE: begin
              if (refill_pending_q) begin
                do_refill = 1'b1;
              end else if (bcnt_new >= need) begin
                bsum_d             = '0;
                bcnt_d             = '0;
                div_req_d.start    = 1'b1;
                div_req_d.dividend = ltavg_pkg::DIV_W'(bsum_new);
                div_req_d.divisor  = ltavg_pkg::DVSR_W'(bcnt_new);
                state_d            = ST_BDIV;
              end else begin
                bsum_d = bsum_new;
                bcnt_d = bcnt_new;
              end
            end
            default: ;
          endcase
        end
      end

      ST_BDIV: begin
        if (div_rsp.done) begin
          if (smooth_q) begin
            slot_d         = slot_next;
            ram_we         = 1'b1;
            ram_wdata      = div_rsp.quotient[SW-1:0];
            valid_d[slot_next] = 1'b1;
            walk_cnt_d     = '0;
            rd_pend_d      = 1'b0;
            rsum_d         = '0;
            lo_d           = {1'b0, {(SW-1){1'b1}}};
            hi_d           = {1'b1, {(SW-1){1'b0}}};
            state_d        = ST_WALK;
          end else begin
            reading_d = div_rsp.quotient[SW-1:0];
            state_d   = ST_NET;
          end
        end
      end

      ST_WALK: begin
        // issue one read a cycle, fold in the entry read the cycle before
        if (walk_cnt_q < win_act) begin
          walk_cnt_d = walk_cnt_q + 1'b1;
          rd_pend_d  = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
        end
        if (rd_pend_q) begin
          rsum_d = rsum_q + ltavg_pkg::RSUM_W'(ent);
          if (ent < lo_q) lo_d = ent;
          if (ent > hi_q) hi_d = ent;
        end
        if (walk_cnt_q == win_act && !rd_pend_q) begin
          div_req_d.start    = 1'b1;
          div_req_d.dividend = ltavg_pkg::DIV_W'(rsum_q) - ltavg_pkg::DIV_W'(lo_q)
                               - ltavg_pkg::DIV_W'(hi_q);
          div_req_d.divisor  = ltavg_pkg::DVSR_W'(win_act - ltavg_pkg::WIN_W'(2));
          state_d            = ST_TDIV;
        end
      end

      ST_TDIV: begin
        if (div_rsp.done) begin
          reading_d = div_rsp.quotient[SW-1:0];
          state_d   = ST_NET;
        end
      end

      ST_NET: begin
        last_d             = reading_q;
        net_d              = ltavg_pkg::NET_W'(reading_q) - ltavg_pkg::NET_W'(tare_q);
        div_req_d.start    = 1'b1;
        div_req_d.dividend = {ltavg_pkg::NET_W'(reading_q) - ltavg_pkg::NET_W'(tare_q), 8'h00};
        div_req_d.divisor  = cal_eff;
        state_d            = ST_UDIV;
      end

      ST_UDIV: begin
        if (div_rsp.done) begin
          units_d = div_rsp.quotient;
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d   = 1'b1;
          out_reading_d = reading_q;
          out_net_d     = net_q;
          out_units_d   = units_q;
          state_d       = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // ring refill: every entry is marked unwritten and so reads as the fill value at once
    if (do_refill) begin
      fill_d           = refill_val;
      valid_d          = '0;
      slot_d           = '0;
      bsum_d           = '0;
      bcnt_d           = '0;
      refill_pending_d = 1'b0;
    end

    // register writes
    if (cfg_wr) begin
      unique case (cfg_i.index)
        ltavg_pkg::REG_SPR:    spr_d = cfg_i.data[ltavg_pkg::SPR_W-1:0];
        ltavg_pkg::REG_SMOOTH: begin
          smooth_d         = cfg_i.data[0];
          refill_pending_d = 1'b1;
        end
        ltavg_pkg::REG_WINDOW: begin
          if (cfg_i.data[ltavg_pkg::WIN_W-1:0] != window_q) begin
            window_d         = cfg_i.data[ltavg_pkg::WIN_W-1:0];
            refill_pending_d = 1'b1;
          end
        end
        ltavg_pkg::REG_CAL:    cal_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      spr_q            <= ltavg_pkg::SPR_RST;
      smooth_q         <= ltavg_pkg::SMOOTH_RST;
      window_q         <= ltavg_pkg::WINDOW_RST;
      cal_q            <= ltavg_pkg::CAL_RST;
      bsum_q           <= '0;
      bcnt_q           <= '0;
      tare_q           <= '0;
      last_q           <= '0;
      refill_pending_q <= 1'b1;
      slot_q           <= '0;
      fill_q           <= '0;
      valid_q          <= '0;
      walk_cnt_q       <= '0;
      rd_pend_q        <= 1'b0;
      rd_valid_q       <= 1'b0;
      rsum_q           <= '0;
      lo_q             <= '0;
      hi_q             <= '0;
      reading_q        <= '0;
      net_q            <= '0;
      units_q          <= '0;
      out_valid_q      <= 1'b0;
      out_reading_q    <= '0;
      out_net_q        <= '0;
      out_units_q      <= '0;
      div_req_q        <= '0;
    end else begin
      state_q          <= state_d;
      spr_q            <= spr_d;
      smooth_q         <= smooth_d;
      window_q         <= window_d;
      cal_q            <= cal_d;
      bsum_q           <= bsum_d;
      bcnt_q           <= bcnt_d;
      tare_q           <= tare_d;
      last_q           <= last_d;
      refill_pending_q <= refill_pending_d;
      slot_q           <= slot_d;
      fill_q           <= fill_d;
      valid_q          <= valid_d;
      walk_cnt_q       <= walk_cnt_d;
      rd_pend_q        <= rd_pend_d;
      rd_valid_q       <= rd_valid_d;
      rsum_q           <= rsum_d;
      lo_q             <= lo_d;
      hi_q             <= hi_d;
      reading_q        <= reading_d;
      net_q            <= net_d;
      units_q          <= units_d;
      out_valid_q      <= out_valid_d;
      out_reading_q    <= out_reading_d;
      out_net_q        <= out_net_d;
      out_units_q      <= out_units_d;
      div_req_q        <= div_req_d;
    end
  end

  // checks
  `LTAVG_ASSERT_NOW(a_div_start_idle, clk_i, rst_ni, div_req_q.start, !div_rsp.busy, "divider started while busy")
  `LTAVG_ASSERT_NOW(a_div_done_waited, clk_i, rst_ni, div_rsp.done, (state_q == ST_BDIV) || (state_q == ST_TDIV) || (state_q == ST_UDIV), "divider result with no state waiting for it")
  `LTAVG_ASSERT_NOW(a_walk_bound, clk_i, rst_ni, state_q == ST_WALK, walk_cnt_q <= win_act, "ring walk ran past the window")
  `LTAVG_ASSERT_NOW(a_slot_bound, clk_i, rst_ni, !refill_pending_q, {1'b0, slot_q} < win_act, "write slot outside the active window")
  `LTAVG_ASSERT_NEXT(a_tare_refills, clk_i, rst_ni, in_fire && (in_i.mode == ltavg_pkg::MODE_TARE) && !cfg_wr, !refill_pending_q && (valid_q == '0), "tare did not refill the ring")

endmodule

[design/ltavg_ram.sv]
`timescale 1ns / 1ps

module ltavg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/ltavg_div.sv]
`timescale 1ns / 1ps

module ltavg_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ltavg_pkg::div_req_t req_i,
  output ltavg_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = ltavg_pkg::DIV_W;
  localparam int unsigned D = ltavg_pkg::DVSR_W;

  logic                              busy_q;
  logic                              done_q;
  logic [ltavg_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic                              neg_q;
  logic [W-1:0]                      shreg_q;
  logic [D-1:0]                      rem_q;
  logic [D-1:0]                      dvsr_q;
  logic [D:0]                        trial;
  logic [D:0]                        diff;
  logic                              take;
  logic [W-1:0]                      mag_in;

  // restoring step: one quotient bit per cycle
  always_comb begin
    trial  = {rem_q, shreg_q[W-1]};
    diff   = trial - {1'b0, dvsr_q};
    take   = trial >= {1'b0, dvsr_q};
    mag_in = req_i.dividend[W-1] ? (~req_i.dividend + W'(1)) : req_i.dividend;
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= ltavg_pkg::DIV_CNT_W'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ltavg_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      neg_q   <= req_i.dividend[W-1];
      shreg_q <= mag_in;
      rem_q   <= '0;
      dvsr_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q   <= take ? diff[D-1:0] : trial[D-1:0];
      shreg_q <= {shreg_q[W-2:0], take};
    end
  end

  // quotient sign restored on the way out
  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? $signed(~shreg_q + W'(1)) : $signed(shreg_q);

endmodule
